/* sv/cse_pkg.sv */
// Shared constants, state encoding and field widths of the comb sort engine.
package cse_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_BITS_DEF   = 16;

    localparam int VALUE_IN_W  = 16;
    localparam int VALUE_OUT_W = 16;
    localparam int CFG_W       = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Gap shrink ratio 10/13 (exact integer form of division by 1.3)
    localparam int SHRINK_NUM = 10;
    localparam int SHRINK_DEN = 13;

    typedef enum logic [2:0] {
        S_LOAD,
        S_GAP1,
        S_GAP2,
        S_CHK,
        S_CMP,
        S_SWP,
        S_ORD,
        S_OWAIT
    } t_state;

endpackage

/* sv/cse_if.sv */
// Valid/ready channel interfaces for input values and sorted results.
interface cse_in_if;
    logic                            valid;
    logic                            ready;
    logic [cse_pkg::VALUE_IN_W-1:0]  value_in;

    modport source (output valid, output value_in, input ready);
    modport sink   (input valid, input value_in, output ready);
endinterface

interface cse_out_if;
    logic                            valid;
    logic                            ready;
    logic [cse_pkg::VALUE_OUT_W-1:0] value_out;
    logic                            is_last;

    modport source (output valid, output value_out, output is_last, input ready);
    modport sink   (input valid, input value_out, input is_last, output ready);
endinterface

/* sv/cse_ram.sv */
// Generic RAM: one write port, two registered read ports.
module cse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* sv/cse_shrink.sv */
// Gap shrink unit: max(1, floor(gap*10/13)) by reciprocal multiply and one correction step.
module cse_shrink #(
    parameter int MAX_ELEMENTS = cse_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_start,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0] i_gap,
    output logic [$clog2(MAX_ELEMENTS+1)-1:0] o_gap,
    output logic                              o_final
);
    import cse_pkg::*;

    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int PW  = CW + 4;
    localparam int SH  = PW;
    localparam int K   = (1 << SH) / SHRINK_DEN;
    localparam int KW  = $clog2(K + 1);
    localparam int PRW = PW + KW;

    logic [PW-1:0]  p;
    logic [PW-1:0]  r_p;
    logic [PRW-1:0] r_prod;
    logic [KW-1:0]  q0;
    logic [PW-1:0]  t13;
    logic [PW-1:0]  rem;
    logic [CW-1:0]  q;

    assign p = PW'(i_gap) * PW'(SHRINK_NUM);

    // Stage the product so the correction sees a registered value
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p    <= p;
            r_prod <= PRW'(p) * PRW'(K);
        end
    end

    // Estimate is exact or one low; bump it when the remainder reaches the divisor
    always_comb begin
        q0  = r_prod[PRW-1:SH];
        t13 = PW'(q0) * PW'(SHRINK_DEN);
        rem = r_p - t13;
        q   = CW'(q0) + ((rem >= PW'(SHRINK_DEN)) ? CW'(1) : CW'(0));
        o_final = (q <= CW'(1));
        o_gap   = o_final ? CW'(1) : q;
    end

endmodule

/* sv/comb_sort_engine_top.sv */
// Comb sort engine top level: load buffer, compare-swap sequencer and sorted output.
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        value_in[15:0]
//  o_out     out  valid/ready        value_out[15:0], is_last
//  i_cfg     in   i_cfg_we (no wait) i_cfg_wdata[6:0] = element_count
//
//  Loading accepts one request per cycle; i_in.ready is high only while loading.
//  The sort runs through one comparator and one two-read RAM: a compare reads in S_CHK
//  and compares in S_CMP, a swap adds S_SWP, a pass adds S_GAP1 and S_GAP2 for the gap
//  shrink and S_CHK for the end check. Output is a RAM read, then the output register.
//  A stalled o_out holds the output register and the sequencer in place.
//  Reset is synchronous, active low; element_count resets to 64, the buffer is not cleared.
module comb_sort_engine_top #(
    parameter int MAX_ELEMENTS = cse_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = cse_pkg::VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cse_pkg::CFG_W-1:0] i_cfg_wdata,
    cse_in_if.sink                    i_in,
    cse_out_if.source                 o_out
);
    import cse_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = $clog2(MAX_ELEMENTS);

    // Control registers
    t_state           r_state,  n_state;
    logic [CFG_W-1:0] r_cfg;
    logic [CW-1:0]    r_load,   n_load;
    logic [CW-1:0]    r_n,      n_n;
    logic [CW-1:0]    r_gap,    n_gap;
    logic [CW-1:0]    r_idx,    n_idx;
    logic             r_last,   n_last;
    logic             r_ovalid, n_ovalid;

    // Payload registers
    logic [VALUE_BITS-1:0]  r_hold,  n_hold;
    logic [VALUE_OUT_W-1:0] r_odata, n_odata;
    logic                   r_olast, n_olast;

    // RAM and shrink unit hookup
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [VALUE_BITS-1:0] rd_a, rd_b;
    logic                  shrink_start;
    logic [CW-1:0]         shrink_gap;
    logic                  shrink_final;

    logic [CW-1:0]   eff_count;
    logic [CW-1:0]   load_next;
    logic [CW:0]     j_idx;
    logic            pass_more;
    logic            idx_is_end;
    logic            out_free;
    logic [63:0]     in_wide;
    logic [63:0]     out_wide;

    cse_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (r_idx[AW-1:0]),
        .i_raddr_b (j_idx[AW-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    cse_shrink #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_shrink (
        .i_clk   (i_clk),
        .i_start (shrink_start),
        .i_gap   (r_gap),
        .o_gap   (shrink_gap),
        .o_final (shrink_final)
    );

    // Run length: zero acts as one, anything past the buffer acts as full
    always_comb begin
        if (r_cfg == '0) begin
            eff_count = CW'(1);
        end else if (int'(r_cfg) > MAX_ELEMENTS) begin
            eff_count = CW'(MAX_ELEMENTS);
        end else begin
            eff_count = CW'(r_cfg);
        end
    end

    assign load_next  = r_load + CW'(1);
    assign j_idx      = {1'b0, r_idx} + {1'b0, r_gap};
    assign pass_more  = (j_idx < {1'b0, r_n});
    assign idx_is_end = (r_idx == r_n - CW'(1));
    assign out_free   = !r_ovalid || o_out.ready;

    // Keep the low VALUE_BITS of the input, present the low 16 bits on output
    assign in_wide  = 64'(i_in.value_in);
    assign out_wide = 64'(rd_a);

    assign i_in.ready      = (r_state == S_LOAD);
    assign o_out.valid     = r_ovalid;
    assign o_out.value_out = r_odata;
    assign o_out.is_last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cfg    <= CFG_RESET;
            r_load   <= '0;
            r_n      <= '0;
            r_gap    <= '0;
            r_idx    <= '0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_load   <= n_load;
            r_n      <= n_n;
            r_gap    <= n_gap;
            r_idx    <= n_idx;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold  <= n_hold;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state      = r_state;
        n_load       = r_load;
        n_n          = r_n;
        n_gap        = r_gap;
        n_idx        = r_idx;
        n_last       = r_last;
        n_hold       = r_hold;
        n_odata      = r_odata;
        n_olast      = r_olast;
        n_ovalid     = r_ovalid && !o_out.ready;
        ram_we       = 1'b0;
        ram_waddr    = r_idx[AW-1:0];
        ram_wdata    = rd_b;
        shrink_start = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (i_in.valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_load[AW-1:0];
                    ram_wdata = in_wide[VALUE_BITS-1:0];
                    n_load    = load_next;
                    // Run complete: sort everything loaded, gap starts at the count
                    if (load_next >= eff_count) begin
                        n_n     = load_next;
                        n_gap   = load_next;
                        n_state = S_GAP1;
                    end
                end
            end
            S_GAP1: begin
                shrink_start = 1'b1;
                n_state      = S_GAP2;
            end
            S_GAP2: begin
                n_gap   = shrink_gap;
                n_last  = shrink_final;
                n_idx   = '0;
                n_state = S_CHK;
            end
            S_CHK: begin
                // Reads of i and i+gap are issued here
                if (pass_more) begin
                    n_state = S_CMP;
                end else if (r_last) begin
                    n_idx   = '0;
                    n_state = S_ORD;
                end else begin
                    n_state = S_GAP1;
                end
            end
            S_CMP: begin
                if (rd_a > rd_b) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata = rd_b;
                    n_hold    = rd_a;
                    n_last    = 1'b0;
                    n_state   = S_SWP;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_CHK;
                end
            end
            S_SWP: begin
                ram_we    = 1'b1;
                ram_waddr = j_idx[AW-1:0];
                ram_wdata = r_hold;
                n_idx     = r_idx + CW'(1);
                n_state   = S_CHK;
            end
            S_ORD: begin
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                // Hold until the output register frees up
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = out_wide[VALUE_OUT_W-1:0];
                    n_olast  = idx_is_end;
                    if (idx_is_end) begin
                        n_load  = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

/* sv/cse_checker.sv */
// Port-level assertions for the comb sort engine, bound to the top level.
module cse_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [cse_pkg::VALUE_OUT_W-1:0]    i_out_value,
    input logic                               i_out_last
);

    // A pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_value) && $stable(i_out_last))
        else $error("result changed while stalled");

    // No new request is taken while a run is still being emitted
    a_no_load_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready in the middle of an emitted run");

    // Reset clears the output valid
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind comb_sort_engine_top cse_checker u_cse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value_out),
    .i_out_last  (o_out.is_last)
);
